### hw/rtl/bsled_pkg.sv
// Package for the blinking serial LED display driver.
// Holds widths, register indexes, event and part codes, and shared structs.
// No dependencies.
package bsled_pkg;

    localparam int WORD_BITS_DEF = 28;
    localparam int MAX_BITS      = 32;
    localparam int REG_W         = 28;
    localparam int PERIOD_W      = 16;
    localparam int NUM_PARTS     = 7;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 28;
    localparam int OP_W          = 3;
    localparam int PART_W        = 3;

    localparam logic [REG_W-1:0]    MASK_WHOLE_RST = {REG_W{1'b1}};
    localparam logic [PERIOD_W-1:0] PERIOD_RST     = PERIOD_W'(500);
    localparam logic [PERIOD_W-1:0] COUNT_MAX      = {PERIOD_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD = CFG_IDX_W'(7);
    localparam logic [PART_W-1:0]    PART_CUSTOM      = PART_W'(7);

    typedef enum logic [OP_W-1:0] {
        OP_NONE  = 3'd0,
        OP_TICK  = 3'd1,
        OP_UPD   = 3'd2,
        OP_START = 3'd3,
        OP_STOP  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        TX_IDLE,
        TX_INIT,
        TX_WRITE,
        TX_HIGH,
        TX_LATCH
    } t_tx;

    // Post-event view of the image unit, seen by the controller
    typedef struct packed {
        logic pending;
        logic blink_on;
        logic expired;
    } t_ev_flags;

    // Controller step back to the image unit
    typedef struct packed {
        logic clr_pending;
        logic clr_count;
    } t_ctl_fb;

    typedef struct packed {
        logic serial_data;
        logic shift_clock;
        logic latch_enable;
        logic busy;
    } t_pins;

endpackage

### hw/rtl/bsled_in_if.sv
// Input item channel of the LED display driver: valid, ready and event payload.
// Depends on bsled_pkg.
interface bsled_in_if import bsled_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [PART_W-1:0] part;
    logic [REG_W-1:0]  word;

    modport source (output valid, output op, output part, output word, input ready);
    modport sink   (input valid, input op, input part, input word, output ready);
endinterface

### hw/rtl/bsled_out_if.sv
// Result item channel of the LED display driver: valid, ready and pin levels.
// Depends on nothing.
interface bsled_out_if ();
    logic valid;
    logic ready;
    logic serial_data;
    logic shift_clock;
    logic latch_enable;
    logic busy_res;

    modport source (output valid, output serial_data, output shift_clock,
                    output latch_enable, output busy_res, input ready);
    modport sink   (input valid, input serial_data, input shift_clock,
                    input latch_enable, input busy_res, output ready);
endinterface

### hw/rtl/bsled_image.sv
// Image unit: part masks, blink period, display image, blink mask, blink counter.
// Applies one event per accepted item. Depends on bsled_pkg.
module bsled_image import bsled_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [OP_W-1:0]       i_op,
    input  logic [PART_W-1:0]     i_part,
    input  logic [REG_W-1:0]      i_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_ctl_fb               i_fb,
    output t_ev_flags             o_flags,
    output logic [WORD_BITS-1:0]  o_display,
    output logic [WORD_BITS-1:0]  o_blink_image
);

    logic [REG_W-1:0]     r_mask [NUM_PARTS];
    logic [PERIOD_W-1:0]  r_period;
    logic [WORD_BITS-1:0] r_display, n_display;
    logic [WORD_BITS-1:0] r_bmask, n_bmask;
    logic                 r_on, n_on;
    logic                 r_pending, n_pending;
    logic [PERIOD_W-1:0]  r_count, n_count;

    logic [MAX_BITS-1:0]  w_word_ext, w_mask_ext;
    logic [WORD_BITS-1:0] w_word, w_part_mask, w_sel_upd, w_sel_blk;

    // Resize the fixed-width fields to the display word
    assign w_word_ext  = {{(MAX_BITS-REG_W){1'b0}}, i_word};
    assign w_mask_ext  = (i_part != PART_CUSTOM) ?
                         {{(MAX_BITS-REG_W){1'b0}}, r_mask[i_part]} : '0;
    assign w_word      = w_word_ext[WORD_BITS-1:0];
    assign w_part_mask = w_mask_ext[WORD_BITS-1:0];
    assign w_sel_upd   = w_part_mask;
    assign w_sel_blk   = (i_part != PART_CUSTOM) ? w_part_mask : w_word;

    always_comb begin
        n_display = r_display;
        n_bmask   = r_bmask;
        n_on      = r_on;
        n_pending = r_pending;
        n_count   = r_count;
        case (t_op'(i_op))
            OP_TICK: begin
                if (r_on && r_count != COUNT_MAX) begin
                    n_count = r_count + PERIOD_W'(1);
                end
            end
            OP_UPD: begin
                n_display = (w_word & w_sel_upd) | (r_display & ~w_sel_upd);
                n_pending = 1'b1;
            end
            OP_START: begin
                n_bmask = r_bmask | w_sel_blk;
                if (!r_on && n_bmask != '0) begin
                    n_count = '0;
                    n_on    = 1'b1;
                end
            end
            OP_STOP: begin
                // ignored entirely while not blinking
                if (r_on) begin
                    n_bmask = r_bmask & ~w_sel_blk;
                    if (n_bmask == '0) begin
                        n_count = '0;
                        n_on    = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_flags.pending  = n_pending;
    assign o_flags.blink_on = n_on;
    assign o_flags.expired  = (n_count >= r_period);
    assign o_display        = n_display;
    assign o_blink_image    = n_display & ~n_bmask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask[0] <= MASK_WHOLE_RST;
            for (int i = 1; i < NUM_PARTS; i++) begin
                r_mask[i] <= '0;
            end
            r_period <= PERIOD_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_BLINK_PERIOD) begin
                r_period <= i_cfg_data[PERIOD_W-1:0];
            end else begin
                r_mask[i_cfg_idx] <= i_cfg_data[REG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display <= '0;
            r_bmask   <= '0;
            r_on      <= 1'b0;
            r_pending <= 1'b0;
            r_count   <= '0;
        end else if (i_accept) begin
            r_display <= n_display;
            r_bmask   <= n_bmask;
            r_on      <= n_on;
            r_pending <= n_pending & ~i_fb.clr_pending;
            r_count   <= i_fb.clr_count ? '0 : n_count;
        end
    end

endmodule

### hw/rtl/bsled_ctrl.sv
// Transfer controller: starts transfers, toggles blink phase, drives the pins.
// Shifts the word out LSB first and ends with a latch pulse. Depends on bsled_pkg.
module bsled_ctrl import bsled_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  t_ev_flags            i_flags,
    input  logic [WORD_BITS-1:0] i_display,
    input  logic [WORD_BITS-1:0] i_blink_image,
    output t_ctl_fb              o_fb,
    output t_pins                o_pins
);

    localparam int BI_W = $clog2(WORD_BITS + 1);

    t_tx                  r_state, n_state;
    logic [BI_W-1:0]      r_bit, n_bit;
    logic [WORD_BITS-1:0] r_word, n_word;
    logic                 r_data, n_data;
    logic                 r_sclk, n_sclk;
    logic                 r_latch, n_latch;
    logic                 r_phase, n_phase;

    logic                 w_start_upd, w_start_blink, w_last;
    logic [WORD_BITS-1:0] w_shifted;

    assign w_start_upd   = i_flags.pending && !i_flags.blink_on;
    assign w_start_blink = !i_flags.pending && i_flags.blink_on && i_flags.expired;
    assign w_last        = (r_bit >= BI_W'(WORD_BITS));
    assign w_shifted     = r_word >> r_bit;

    always_comb begin
        n_state = r_state;
        case (r_state)
            TX_IDLE: begin
                if (w_start_upd || w_start_blink) begin
                    n_state = TX_INIT;
                end
            end
            TX_INIT:  n_state = w_last ? TX_LATCH : TX_WRITE;
            TX_WRITE: n_state = TX_HIGH;
            TX_HIGH:  n_state = TX_INIT;
            TX_LATCH: n_state = TX_IDLE;
            default:  n_state = TX_IDLE;
        endcase
    end

    always_comb begin
        n_bit   = r_bit;
        n_word  = r_word;
        n_data  = r_data;
        n_sclk  = r_sclk;
        n_latch = r_latch;
        n_phase = r_phase;
        o_fb    = '0;
        case (r_state)
            TX_IDLE: begin
                if (i_flags.pending) begin
                    // drop the pending update; it starts nothing while blinking
                    o_fb.clr_pending = 1'b1;
                    if (!i_flags.blink_on) begin
                        n_word = i_display;
                        n_bit  = '0;
                    end
                end else if (w_start_blink) begin
                    o_fb.clr_count = 1'b1;
                    n_phase        = ~r_phase;
                    n_word         = n_phase ? i_blink_image : i_display;
                    n_bit          = '0;
                end
            end
            TX_INIT: begin
                if (w_last) begin
                    n_latch = 1'b1;
                end else begin
                    n_sclk = 1'b0;
                end
            end
            TX_WRITE: n_data = w_shifted[0];
            TX_HIGH: begin
                n_sclk = 1'b1;
                n_bit  = r_bit + BI_W'(1);
            end
            TX_LATCH: n_latch = 1'b0;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TX_IDLE;
            r_bit   <= '0;
            r_word  <= '0;
            r_data  <= 1'b0;
            r_sclk  <= 1'b0;
            r_latch <= 1'b0;
            r_phase <= 1'b0;
        end else if (i_accept) begin
            r_state <= n_state;
            r_bit   <= n_bit;
            r_word  <= n_word;
            r_data  <= n_data;
            r_sclk  <= n_sclk;
            r_latch <= n_latch;
            r_phase <= n_phase;
        end
    end

    assign o_pins.serial_data  = r_data;
    assign o_pins.shift_clock  = r_sclk;
    assign o_pins.latch_enable = r_latch;
    assign o_pins.busy         = (r_state != TX_IDLE);

endmodule

### hw/rtl/blinking_serial_led_display_driver.sv
// Blinking serial LED display driver, top level. An accepted item's result is
// valid in the next cycle. One item per cycle unless a result stalls; the state
// registers update on each accept and the output valid register parts the sides.
// Reset (synchronous, active low) clears all state and loads register defaults.
// Depends on bsled_pkg, bsled_in_if, bsled_out_if, bsled_image, bsled_ctrl.
module blinking_serial_led_display_driver import bsled_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bsled_in_if.sink              i_item,
    bsled_out_if.source           o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic                 r_out_valid;
    logic                 w_accept;
    t_ev_flags            w_flags;
    t_ctl_fb              w_fb;
    t_pins                w_pins;
    logic [WORD_BITS-1:0] w_display, w_blink_image;

    assign i_item.ready = !r_out_valid || o_res.ready;
    assign w_accept     = i_item.valid && i_item.ready;

    bsled_image #(.WORD_BITS(WORD_BITS)) u_image (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_op         (i_item.op),
        .i_part       (i_item.part),
        .i_word       (i_item.word),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_fb         (w_fb),
        .o_flags      (w_flags),
        .o_display    (w_display),
        .o_blink_image(w_blink_image)
    );

    bsled_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_flags      (w_flags),
        .i_display    (w_display),
        .i_blink_image(w_blink_image),
        .o_fb         (w_fb),
        .o_pins       (w_pins)
    );

    // Pin registers change only on accept, so a stalled result holds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.serial_data  = w_pins.serial_data;
    assign o_res.shift_clock  = w_pins.shift_clock;
    assign o_res.latch_enable = w_pins.latch_enable;
    assign o_res.busy_res     = w_pins.busy;

endmodule

### hw/rtl/bsled_checker.sv
// Port-level checker for the LED display driver, bound to the top level.
// Depends on blinking_serial_led_display_driver ports only.
module bsled_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_sdata,
    input logic i_sclk,
    input logic i_latch,
    input logic i_busy
);

    // Every accepted item yields a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("accepted item produced no result");

    // An empty output stage never stalls the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output stage");

    // Latch pulse only inside a transfer
    a_latch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_latch) |-> i_busy)
        else $error("latch pulse outside a transfer");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_sdata) && $stable(i_sclk) && $stable(i_latch)
         && $stable(i_busy)))
        else $error("stalled result changed");

endmodule

bind blinking_serial_led_display_driver bsled_checker u_bsled_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_item.valid),
    .i_in_ready (i_item.ready),
    .i_out_valid(o_res.valid),
    .i_out_ready(o_res.ready),
    .i_sdata    (o_res.serial_data),
    .i_sclk     (o_res.shift_clock),
    .i_latch    (o_res.latch_enable),
    .i_busy     (o_res.busy_res)
);
